// ----- rtl/qave_pkg.sv -----
// Shared types, constants and the quarter-wave sine table for the quad vertex emitter.
// Used by every module of the block; has no dependencies of its own.
package qave_pkg;

  localparam int SINE_TABLE_BITS = 8;
  localparam int QTR_SIZE        = 1 << SINE_TABLE_BITS;
  localparam int TABLE_IDX_W     = SINE_TABLE_BITS + 1;
  localparam int TABLE_VAL_W     = 15;
  localparam int SINE_W          = 16;
  localparam int TAYLOR_TERMS    = 8;

  localparam int ANGLE_W   = 16;
  localparam int POS_W     = 24;
  localparam int SCALE_W   = 16;
  localparam int WORD_W    = 32;
  localparam int HALF_W    = 16;
  localparam int LOCAL_W   = 32;
  localparam int PROD_W    = 48;
  localparam int ROT_W     = 49;
  localparam int SUM_W     = 50;
  localparam int ROUND_W   = 32;
  localparam int FRAC_SHIFT = 18;

  localparam int NUM_CORNERS    = 4;
  localparam int CFG_IDX_W      = 2;
  localparam int VERTS_PER_ITEM = 6;
  localparam int VERT_IDX_W     = 3;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [ANGLE_W-1:0] QUARTER_TURN = 16'h4000;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] TAYLOR_DIV [TAYLOR_TERMS] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272
  };

  localparam logic signed [SUM_W-1:0]   ROUND_BIAS = 50'sd131072;
  localparam logic signed [ROUND_W-1:0] POS_MAX    = 32'sd8388607;
  localparam logic signed [ROUND_W-1:0] POS_MIN    = -32'sd8388608;

  typedef enum logic [1:0] {
    CORNER_TL = 2'd0,
    CORNER_TR = 2'd1,
    CORNER_BR = 2'd2,
    CORNER_BL = 2'd3
  } corner_t;

  typedef logic [NUM_CORNERS-1:0][WORD_W-1:0] tex_set_t;

  typedef struct packed {
    logic signed [POS_W-1:0]   particle_x;
    logic signed [POS_W-1:0]   particle_y;
    logic [ANGLE_W-1:0]        angle;
    logic signed [SCALE_W-1:0] scale_x;
    logic signed [SCALE_W-1:0] scale_y;
    logic [WORD_W-1:0]         color;
    logic [WORD_W-1:0]         corner_top_left;
    logic [WORD_W-1:0]         corner_top_right;
    logic [WORD_W-1:0]         corner_bottom_right;
    logic [WORD_W-1:0]         corner_bottom_left;
  } in_item_t;

  typedef struct packed {
    logic signed [POS_W-1:0] vertex_x;
    logic signed [POS_W-1:0] vertex_y;
    logic [WORD_W-1:0]       tex_coord;
    logic [WORD_W-1:0]       vertex_color;
    logic                    last_vertex;
  } out_item_t;

  typedef struct packed {
    logic signed [POS_W-1:0]   px;
    logic signed [POS_W-1:0]   py;
    logic signed [SCALE_W-1:0] sx;
    logic signed [SCALE_W-1:0] sy;
    logic [WORD_W-1:0]         color;
    tex_set_t                  corners;
    logic signed [SINE_W-1:0]  sine;
    logic signed [SINE_W-1:0]  cosine;
  } work_t;

  typedef logic [TABLE_VAL_W-1:0] sine_table_t [QTR_SIZE+1];

  function automatic sine_table_t build_sine_table();
    sine_table_t       tbl;
    logic [63:0]       x;
    logic [63:0]       x2;
    logic [63:0]       term;
    logic [63:0]       r;
    logic signed [63:0] sum;
    for (int i = 0; i <= QTR_SIZE; i++) begin
      x    = HALF_PI_Q30 * 64'(i) / 64'(QTR_SIZE);
      x2   = (x * x) >> 30;
      term = x;
      sum  = signed'(x);
      for (int k = 0; k < TAYLOR_TERMS; k++) begin
        term = ((term * x2) >> 30) / TAYLOR_DIV[k];
        if (k[0] == 1'b0) begin
          sum = sum - signed'(term);
        end else begin
          sum = sum + signed'(term);
        end
      end
      if (sum < 0) begin
        sum = '0;
      end
      r = (unsigned'(sum) + 64'd32768) >> 16;
      if (r > 64'd16384) begin
        r = 64'd16384;
      end
      tbl[i] = r[TABLE_VAL_W-1:0];
    end
    return tbl;
  endfunction

  localparam sine_table_t SINE_TABLE = build_sine_table();

  function automatic logic signed [SINE_W-1:0] sine_lookup(input logic [ANGLE_W-1:0] a);
    logic [1:0]             quad;
    logic [TABLE_IDX_W-1:0] f;
    logic [TABLE_IDX_W-1:0] idx;
    logic [SINE_W-1:0]      mag;
    quad = a[ANGLE_W-1 -: 2];
    f    = {1'b0, a[ANGLE_W-3 -: SINE_TABLE_BITS]};
    idx  = quad[0] ? (TABLE_IDX_W'(QTR_SIZE) - f) : f;
    mag  = SINE_W'(SINE_TABLE[idx]);
    return quad[1] ? -signed'(mag) : signed'(mag);
  endfunction

  function automatic corner_t corner_of(input logic [VERT_IDX_W-1:0] v);
    corner_t c;
    unique case (v)
      3'd0:    c = CORNER_TL;
      3'd1:    c = CORNER_TR;
      3'd2:    c = CORNER_BR;
      3'd3:    c = CORNER_TL;
      3'd4:    c = CORNER_BR;
      3'd5:    c = CORNER_BL;
      default: c = CORNER_TL;
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/qave_front.sv -----
// Front end: accepts particles, looks up sine and cosine and packs the work entry.
// Depends on qave_pkg for the item types and the sine table lookup.
module qave_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  qave_pkg::in_item_t in_data,
  output logic              push_valid,
  input  logic              push_ready,
  output qave_pkg::work_t   push_data
);

  logic            held;
  qave_pkg::work_t entry;
  qave_pkg::work_t entry_next;

  assign in_ready   = !held || push_ready;
  assign push_valid = held;
  assign push_data  = entry;

  always_comb begin
    entry_next.px      = in_data.particle_x;
    entry_next.py      = in_data.particle_y;
    entry_next.sx      = in_data.scale_x;
    entry_next.sy      = in_data.scale_y;
    entry_next.color   = in_data.color;
    entry_next.corners = {in_data.corner_bottom_left, in_data.corner_bottom_right,
                          in_data.corner_top_right, in_data.corner_top_left};
    entry_next.sine    = qave_pkg::sine_lookup(in_data.angle);
    entry_next.cosine  = qave_pkg::sine_lookup(in_data.angle + qave_pkg::QUARTER_TURN);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_valid && in_ready) begin
      held <= 1'b1;
    end else if (push_ready) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      entry <= entry_next;
    end
  end

endmodule

// ----- rtl/qave_queue.sv -----
// Short queue of work entries between the front end and the vertex back end.
// Depends on qave_pkg for the entry type and the queue depth.
module qave_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  qave_pkg::work_t push_data,
  output logic            pop_valid,
  input  logic            pop_ready,
  output qave_pkg::work_t pop_data
);

  qave_pkg::work_t                   slots [qave_pkg::QUEUE_DEPTH];
  logic [qave_pkg::QUEUE_PTR_W-1:0] rd_ptr;
  logic [qave_pkg::QUEUE_PTR_W-1:0] wr_ptr;
  logic [qave_pkg::QUEUE_CNT_W-1:0] count;
  logic                              push;
  logic                              pop;

  function automatic logic [qave_pkg::QUEUE_PTR_W-1:0] bump(
    input logic [qave_pkg::QUEUE_PTR_W-1:0] p
  );
    if (p == qave_pkg::QUEUE_PTR_W'(qave_pkg::QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  assign push_ready = (count != qave_pkg::QUEUE_CNT_W'(qave_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

// ----- rtl/qave_back.sv -----
// Back end: transforms the six vertices of each entry, one corner a cycle unless stalled.
// Scale, rotate, sum and round/saturate stages feed a registered output. Depends on qave_pkg.
module qave_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                head_valid,
  output logic                head_ready,
  input  qave_pkg::work_t     head_data,
  input  qave_pkg::tex_set_t  tex,
  output logic                out_valid,
  input  logic                out_ready,
  output qave_pkg::out_item_t out_data
);

  logic                                advance;
  logic                                issue;
  logic [qave_pkg::VERT_IDX_W-1:0]     vcount;
  qave_pkg::corner_t                   sel;
  logic [qave_pkg::WORD_W-1:0]         offset;
  logic signed [qave_pkg::HALF_W-1:0]  ox;
  logic signed [qave_pkg::HALF_W-1:0]  oy;

  logic                                a_valid;
  logic signed [qave_pkg::LOCAL_W-1:0] a_lx;
  logic signed [qave_pkg::LOCAL_W-1:0] a_ly;
  logic signed [qave_pkg::SINE_W-1:0]  a_sine;
  logic signed [qave_pkg::SINE_W-1:0]  a_cosine;
  logic signed [qave_pkg::POS_W-1:0]   a_px;
  logic signed [qave_pkg::POS_W-1:0]   a_py;
  logic [qave_pkg::WORD_W-1:0]         a_tex;
  logic [qave_pkg::WORD_W-1:0]         a_color;
  logic                                a_last;

  logic                                b_valid;
  logic signed [qave_pkg::PROD_W-1:0]  b_xc;
  logic signed [qave_pkg::PROD_W-1:0]  b_ys;
  logic signed [qave_pkg::PROD_W-1:0]  b_xs;
  logic signed [qave_pkg::PROD_W-1:0]  b_yc;
  logic signed [qave_pkg::POS_W-1:0]   b_px;
  logic signed [qave_pkg::POS_W-1:0]   b_py;
  logic [qave_pkg::WORD_W-1:0]         b_tex;
  logic [qave_pkg::WORD_W-1:0]         b_color;
  logic                                b_last;

  logic                                c_valid;
  logic signed [qave_pkg::ROT_W-1:0]   c_rx;
  logic signed [qave_pkg::ROT_W-1:0]   c_ry;
  logic signed [qave_pkg::POS_W-1:0]   c_px;
  logic signed [qave_pkg::POS_W-1:0]   c_py;
  logic [qave_pkg::WORD_W-1:0]         c_tex;
  logic [qave_pkg::WORD_W-1:0]         c_color;
  logic                                c_last;

  logic signed [qave_pkg::POS_W-1:0]   vx_next;
  logic signed [qave_pkg::POS_W-1:0]   vy_next;

  function automatic logic signed [qave_pkg::POS_W-1:0] place(
    input logic signed [qave_pkg::ROT_W-1:0] rot,
    input logic signed [qave_pkg::POS_W-1:0] pos
  );
    logic signed [qave_pkg::SUM_W-1:0]   sum;
    logic signed [qave_pkg::ROUND_W-1:0] rounded;
    sum = qave_pkg::SUM_W'(rot) + (qave_pkg::SUM_W'(pos) <<< qave_pkg::FRAC_SHIFT)
          + qave_pkg::ROUND_BIAS;
    rounded = sum[qave_pkg::SUM_W-1 -: qave_pkg::ROUND_W];
    if (rounded > qave_pkg::POS_MAX) begin
      rounded = qave_pkg::POS_MAX;
    end else if (rounded < qave_pkg::POS_MIN) begin
      rounded = qave_pkg::POS_MIN;
    end
    return rounded[qave_pkg::POS_W-1:0];
  endfunction

  assign advance    = !out_valid || out_ready;
  assign issue      = head_valid && advance;
  assign head_ready = advance && (vcount == qave_pkg::VERT_IDX_W'(qave_pkg::VERTS_PER_ITEM - 1));
  assign sel        = qave_pkg::corner_of(vcount);
  assign offset     = head_data.corners[sel];
  assign ox         = signed'(offset[qave_pkg::WORD_W-1 -: qave_pkg::HALF_W]);
  assign oy         = signed'(offset[qave_pkg::HALF_W-1:0]);
  assign vx_next    = place(c_rx, c_px);
  assign vy_next    = place(c_ry, c_py);

  always_ff @(posedge clk) begin
    if (rst) begin
      vcount    <= '0;
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      c_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      if (issue) begin
        vcount <= head_ready ? '0 : vcount + 1'b1;
      end
      a_valid   <= issue;
      b_valid   <= a_valid;
      c_valid   <= b_valid;
      out_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      a_lx     <= qave_pkg::LOCAL_W'(ox) * qave_pkg::LOCAL_W'(head_data.sx);
      a_ly     <= qave_pkg::LOCAL_W'(oy) * qave_pkg::LOCAL_W'(head_data.sy);
      a_sine   <= head_data.sine;
      a_cosine <= head_data.cosine;
      a_px     <= head_data.px;
      a_py     <= head_data.py;
      a_tex    <= tex[sel];
      a_color  <= head_data.color;
      a_last   <= head_ready;

      b_xc    <= qave_pkg::PROD_W'(a_lx) * qave_pkg::PROD_W'(a_cosine);
      b_ys    <= qave_pkg::PROD_W'(a_ly) * qave_pkg::PROD_W'(a_sine);
      b_xs    <= qave_pkg::PROD_W'(a_lx) * qave_pkg::PROD_W'(a_sine);
      b_yc    <= qave_pkg::PROD_W'(a_ly) * qave_pkg::PROD_W'(a_cosine);
      b_px    <= a_px;
      b_py    <= a_py;
      b_tex   <= a_tex;
      b_color <= a_color;
      b_last  <= a_last;

      c_rx    <= qave_pkg::ROT_W'(b_xc) - qave_pkg::ROT_W'(b_ys);
      c_ry    <= qave_pkg::ROT_W'(b_xs) + qave_pkg::ROT_W'(b_yc);
      c_px    <= b_px;
      c_py    <= b_py;
      c_tex   <= b_tex;
      c_color <= b_color;
      c_last  <= b_last;

      out_data.vertex_x     <= vx_next;
      out_data.vertex_y     <= vy_next;
      out_data.tex_coord    <= c_tex;
      out_data.vertex_color <= c_color;
      out_data.last_vertex  <= c_last;
    end
  end

endmodule

// ----- rtl/quad_affine_vertex_emitter.sv -----
// The first vertex of a particle passes the front-end register, the queue and back-end stages
// a, b and c before it reaches the output register.
// One vertex per cycle while the output is not stalled, six per particle, set by the single
// vertex output channel; a two-entry queue lets the input side run ahead.
// Reset (rst, synchronous): empties front end, queue and pipeline, clears texture registers.
module quad_affine_vertex_emitter (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  qave_pkg::in_item_t               in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output qave_pkg::out_item_t              out_data,
  input  logic                             cfg_write,
  input  logic [qave_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [qave_pkg::WORD_W-1:0]      cfg_data
);

  qave_pkg::tex_set_t tex;
  logic               push_valid;
  logic               push_ready;
  qave_pkg::work_t    push_data;
  logic               head_valid;
  logic               head_ready;
  qave_pkg::work_t    head_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      tex <= '0;
    end else if (cfg_write) begin
      tex[cfg_index] <= cfg_data;
    end
  end

  qave_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  qave_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (head_valid),
    .pop_ready  (head_ready),
    .pop_data   (head_data)
  );

  qave_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_ready (head_ready),
    .head_data  (head_data),
    .tex        (tex),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

// ----- rtl/qave_checker.sv -----
// Port-level checks for the quad vertex emitter, attached by the bind at the end.
// Depends on qave_pkg for the item types and the vertex count.
module qave_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input qave_pkg::out_item_t out_data
);

  logic                                 beat;
  logic [qave_pkg::VERT_IDX_W-1:0]      beat_idx;
  logic [3:0]                           pending;
  logic signed [qave_pkg::POS_W-1:0]    first_x;
  logic signed [qave_pkg::POS_W-1:0]    first_y;
  logic [qave_pkg::WORD_W-1:0]          first_color;
  logic                                 take_in;
  logic                                 done_out;

  assign beat     = out_valid && out_ready;
  assign take_in  = in_valid && in_ready;
  assign done_out = beat && out_data.last_vertex;

  always_ff @(posedge clk) begin
    if (rst) begin
      beat_idx <= '0;
      pending  <= '0;
    end else begin
      if (beat) begin
        beat_idx <= (beat_idx == qave_pkg::VERT_IDX_W'(qave_pkg::VERTS_PER_ITEM - 1)) ?
                    '0 : beat_idx + 1'b1;
      end
      if (take_in && !done_out) begin
        pending <= pending + 1'b1;
      end else if (done_out && !take_in) begin
        pending <= pending - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (beat && beat_idx == '0) begin
      first_x     <= out_data.vertex_x;
      first_y     <= out_data.vertex_y;
      first_color <= out_data.vertex_color;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("Output beat changed while stalled.");

  a_last_mark: assert property (@(posedge clk) disable iff (rst)
    beat |-> (out_data.last_vertex ==
              (beat_idx == qave_pkg::VERT_IDX_W'(qave_pkg::VERTS_PER_ITEM - 1))))
    else $error("Last vertex mark is not on the sixth beat.");

  a_no_orphan: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != '0)
    else $error("Vertex shown with no particle outstanding.");

  a_color_same: assert property (@(posedge clk) disable iff (rst)
    beat && beat_idx != '0 |-> out_data.vertex_color == first_color)
    else $error("Vertex color changed within a particle.");

  a_repeat_corner: assert property (@(posedge clk) disable iff (rst)
    beat && beat_idx == qave_pkg::VERT_IDX_W'(3) |->
      out_data.vertex_x == first_x && out_data.vertex_y == first_y)
    else $error("Repeated top-left vertex differs from the first one.");

endmodule

bind quad_affine_vertex_emitter qave_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
